>>> src/ebsc_pkg.sv
// Shared types, constants and helper functions for the EBML element scanner.
package ebsc_pkg;

	localparam int unsigned CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET_ID = 1'b0,
		CFG_STOP_ID   = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_ID      = 2'd0,
		PH_SIZE    = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_scan;
	} in_t;

	typedef struct packed {
		logic [31:0] element_id;
		logic [3:0]  id_length;
		logic        id_too_long;
		logic [55:0] size_value;
		logic [3:0]  size_length;
		logic        size_undefined;
		logic        size_zero;
		logic        size_marker_missing;
		logic        matched;
		logic        stop_seen;
	} out_t;

	// Varint length from the leading set bit; a zero byte counts as eight.
	function automatic logic [3:0] varint_len(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd8;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) n = 4'(8 - i);
		end
		return n;
	endfunction

	// Value bits of a size varint of the given length (7 bits per byte).
	function automatic logic [55:0] size_mask(input logic [3:0] len);
		logic [55:0] m;
		unique case (len)
			4'd1:    m = 56'h7F;
			4'd2:    m = 56'h3FFF;
			4'd3:    m = 56'h1F_FFFF;
			4'd4:    m = 56'hFFF_FFFF;
			4'd5:    m = 56'h7_FFFF_FFFF;
			4'd6:    m = 56'h3FF_FFFF_FFFF;
			4'd7:    m = 56'h1_FFFF_FFFF_FFFF;
			default: m = 56'hFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

>>> src/ebsc_cfg_regs.sv
// Configuration registers: target ID and stop ID.
module ebsc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [ebsc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [31:0]                   wr_data,
	output logic [31:0]                   target_id,
	output logic [31:0]                   stop_id
);
	import ebsc_pkg::*;

	logic [31:0] target_id_q;
	logic [31:0] stop_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_id_q <= '0;
			stop_id_q   <= '0;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_TARGET_ID: target_id_q <= wr_data;
				CFG_STOP_ID:   stop_id_q   <= wr_data;
				default: ;
			endcase
		end
	end

	assign target_id = target_id_q;
	assign stop_id   = stop_id_q;

endmodule

>>> src/ebsc_parser.sv
// Header parser: per-byte state update and result record generation.
module ebsc_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  ebsc_pkg::in_t  item,
	input  logic [31:0]    target_id,
	input  logic [31:0]    stop_id,
	output logic           res_valid,
	output ebsc_pkg::out_t res
);
	import ebsc_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  bytes_left_q, bytes_left_d;
	logic [31:0] id_shift_q, id_shift_d;
	logic [3:0]  id_len_q, id_len_d;
	logic [63:0] size_shift_q, size_shift_d;
	logic [3:0]  size_len_q, size_len_d;
	logic [55:0] payload_left_q, payload_left_d;
	logic        halted_q, halted_d;

	// state as seen by this byte, after an optional restart
	logic        clr;
	phase_t      e_phase;
	logic [3:0]  e_bl;
	logic [31:0] e_id;
	logic [3:0]  e_id_len;
	logic [63:0] e_size;
	logic [3:0]  e_size_len;
	logic [55:0] e_pay;
	logic        e_halt;

	assign clr        = item.start_scan;
	assign e_phase    = clr ? PH_ID : phase_q;
	assign e_bl       = clr ? 4'd0 : bytes_left_q;
	assign e_id       = clr ? 32'd0 : id_shift_q;
	assign e_id_len   = clr ? 4'd0 : id_len_q;
	assign e_size     = clr ? 64'd0 : size_shift_q;
	assign e_size_len = clr ? 4'd0 : size_len_q;
	assign e_pay      = clr ? 56'd0 : payload_left_q;
	assign e_halt     = clr ? 1'b0 : halted_q;

	logic [3:0] blen;
	logic [3:0] bl_dec;
	assign blen   = varint_len(item.data_byte);
	assign bl_dec = (e_bl != 4'd0) ? e_bl - 4'd1 : 4'd0;

	// ID varint
	logic        id_first;
	logic [3:0]  id_len_new;
	logic [3:0]  id_bl_new;
	logic [3:0]  id_taken;
	logic [31:0] id_shift_new;
	assign id_first   = (e_id_len == 4'd0);
	assign id_len_new = id_first ? blen : e_id_len;
	assign id_bl_new  = id_first ? blen - 4'd1 : bl_dec;
	assign id_taken   = e_id_len - e_bl;
	always_comb begin
		if (id_first) id_shift_new = {24'd0, item.data_byte};
		else if (id_taken < 4'd4) id_shift_new = {e_id[23:0], item.data_byte};
		else id_shift_new = e_id;
	end

	// size varint
	logic        sz_first;
	logic [3:0]  sz_len_new;
	logic [3:0]  sz_bl_new;
	logic [63:0] sz_shift_new;
	logic [55:0] sz_mask;
	logic [55:0] sz_value;
	logic        sz_undef;
	logic        sz_missing;
	logic        sz_done;
	assign sz_first     = (e_size_len == 4'd0);
	assign sz_len_new   = sz_first ? blen : e_size_len;
	assign sz_bl_new    = sz_first ? blen - 4'd1 : bl_dec;
	assign sz_shift_new = sz_first ? {56'd0, item.data_byte} : {e_size[55:0], item.data_byte};
	assign sz_mask      = size_mask(sz_len_new);
	assign sz_value     = sz_shift_new[55:0] & sz_mask;
	// all-ones pattern: marker bit plus every value bit set, nothing above
	assign sz_undef     = (sz_shift_new[63:57] == 7'd0) &&
	                      (sz_shift_new[56:0] == {sz_mask, 1'b1});
	assign sz_missing   = (sz_len_new == 4'd8) && (sz_shift_new[63:56] == 8'd0);
	assign sz_done      = (sz_bl_new == 4'd0);

	logic too_long;
	logic hit_target;
	logic hit_stop;
	assign too_long   = (e_id_len > 4'd4);
	assign hit_target = !too_long && (target_id != 32'd0) && (e_id == target_id);
	assign hit_stop   = !too_long && (stop_id != 32'd0) && (e_id == stop_id);

	logic [55:0] pay_dec;
	assign pay_dec = (e_pay != 56'd0) ? e_pay - 56'd1 : 56'd0;

	// next state
	always_comb begin
		phase_d        = e_phase;
		bytes_left_d   = e_bl;
		id_shift_d     = e_id;
		id_len_d       = e_id_len;
		size_shift_d   = e_size;
		size_len_d     = e_size_len;
		payload_left_d = e_pay;
		halted_d       = e_halt;
		if (!e_halt) begin
			unique case (e_phase)
				PH_PAYLOAD: begin
					payload_left_d = pay_dec;
					if (pay_dec == 56'd0) begin
						phase_d      = PH_ID;
						id_len_d     = 4'd0;
						bytes_left_d = 4'd0;
					end
				end
				PH_SIZE: begin
					size_len_d   = sz_len_new;
					size_shift_d = sz_shift_new;
					bytes_left_d = sz_bl_new;
					if (sz_done) begin
						if (hit_stop) begin
							halted_d     = 1'b1;
							phase_d      = PH_ID;
							id_len_d     = 4'd0;
							bytes_left_d = 4'd0;
						end else if (sz_undef || sz_value == 56'd0) begin
							phase_d      = PH_ID;
							id_len_d     = 4'd0;
							bytes_left_d = 4'd0;
						end else begin
							phase_d        = PH_PAYLOAD;
							payload_left_d = sz_value;
							bytes_left_d   = 4'd0;
						end
					end
				end
				default: begin
					id_len_d     = id_len_new;
					id_shift_d   = id_shift_new;
					bytes_left_d = id_bl_new;
					if (id_bl_new == 4'd0) begin
						phase_d    = PH_SIZE;
						size_len_d = 4'd0;
					end
				end
			endcase
		end
	end

	// result record
	always_comb begin
		res_valid               = !e_halt && (e_phase == PH_SIZE) && sz_done;
		res.element_id          = e_id;
		res.id_length           = e_id_len;
		res.id_too_long         = too_long;
		res.size_value          = sz_value;
		res.size_length         = sz_len_new;
		res.size_undefined      = sz_undef;
		res.size_zero           = (sz_value == 56'd0) && !sz_undef;
		res.size_marker_missing = sz_missing;
		res.matched             = hit_target;
		res.stop_seen           = hit_stop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_ID;
			bytes_left_q   <= '0;
			id_shift_q     <= '0;
			id_len_q       <= '0;
			size_shift_q   <= '0;
			size_len_q     <= '0;
			payload_left_q <= '0;
			halted_q       <= 1'b0;
		end else if (step) begin
			phase_q        <= phase_d;
			bytes_left_q   <= bytes_left_d;
			id_shift_q     <= id_shift_d;
			id_len_q       <= id_len_d;
			size_shift_q   <= size_shift_d;
			size_len_q     <= size_len_d;
			payload_left_q <= payload_left_d;
			halted_q       <= halted_d;
		end
	end

endmodule

>>> src/ebml_element_scanner_unit.sv
// EBML element scanner top level: input register, parser, result register.
//
// Bytes of an EBML stream enter on the in channel (valid/ready, one byte per
// transfer); start_scan set on a byte restarts header parsing at that byte.
// Each completed element header (ID varint followed by size varint) yields
// one record on the out channel; ID bytes, size bytes and skipped payload
// bytes yield nothing. After the header of the stop element no records are
// produced until start_scan is seen again.
// Configuration: cfg channel, index 0 target ID, index 1 stop ID; always
// ready, to be written only while the scanner is idle.
// Path: a byte is captured in the input register, and its record is loaded
// into the result register as the byte advances out of it; out_valid is
// driven by the result register.
// Throughput: one byte per cycle while no record waits on a stalled receiver;
// the per-byte parser update is combinational shift, mask and compare logic.
// Reset clears the parser state, both ID registers and both valid flags.
// When the receiver stalls with a record pending, bytes that produce no
// record keep flowing; a byte that would produce a record waits in the input
// register, which then deasserts in_ready.
module ebml_element_scanner_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ebsc_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ebsc_pkg::out_t                 out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ebsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import ebsc_pkg::*;

	logic        in_valid_s1;
	in_t         in_data_s1;
	logic        out_valid_s2;
	out_t        out_data_s2;
	logic [31:0] target_id;
	logic [31:0] stop_id;
	logic        res_valid;
	out_t        res;
	logic        advance;

	assign cfg_ready = 1'b1;

	ebsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cfg_valid && cfg_ready),
		.wr_index  (cfg_index),
		.wr_data   (cfg_data),
		.target_id (target_id),
		.stop_id   (stop_id)
	);

	ebsc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (in_data_s1),
		.target_id (target_id),
		.stop_id   (stop_id),
		.res_valid (res_valid),
		.res       (res)
	);

	// a byte moves on unless it makes a record and the result slot is still full
	assign advance  = in_valid_s1 && (!res_valid || !out_valid_s2 || out_ready);
	assign in_ready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) in_data_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) out_data_s2 <= res;
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

endmodule

>>> test/ebsc_checker.sv
// Channel monitor, header predictor and record comparison for the EBML element scanner.
module ebsc_checker
	import ebsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_t                  in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_t                 out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output int unsigned          fail_count,
	output int unsigned          pending
);

	phase_t      scan_phase;
	logic [3:0]  left_cnt;
	logic [31:0] id_acc;
	logic [3:0]  id_len;
	logic [63:0] size_acc;
	logic [3:0]  size_len;
	logic [55:0] skip_cnt;
	logic        halted;
	logic [31:0] target_id;
	logic [31:0] stop_id;
	out_t        expected_headers[$];

	// Varint length from the position of the leading one; no marker reads as eight.
	function automatic logic [3:0] marker_len(input logic [7:0] b);
		casez (b)
			8'b1???????: return 4'd1;
			8'b01??????: return 4'd2;
			8'b001?????: return 4'd3;
			8'b0001????: return 4'd4;
			8'b00001???: return 4'd5;
			8'b000001??: return 4'd6;
			8'b0000001?: return 4'd7;
			default:     return 4'd8;
		endcase
	endfunction

	task automatic clear_scan();
		scan_phase = PH_ID;
		left_cnt   = '0;
		id_acc     = '0;
		id_len     = '0;
		size_acc   = '0;
		size_len   = '0;
		skip_cnt   = '0;
		halted     = 1'b0;
	endtask

	task automatic await_header();
		scan_phase = PH_ID;
		id_len     = '0;
		left_cnt   = '0;
	endtask

	task automatic scan_byte(input in_t item);
		logic [7:0]  b;
		logic [63:0] all_ones;
		logic [63:0] value_bits;
		logic        undef;
		logic        long_id;
		out_t        rec;
		b = item.data_byte;
		if (item.start_scan)
			clear_scan();
		if (halted)
			return;
		if (scan_phase == PH_PAYLOAD) begin
			if (skip_cnt != 0)
				skip_cnt--;
			if (skip_cnt == 0)
				await_header();
			return;
		end
		if (scan_phase != PH_SIZE) begin
			if (id_len == 0) begin
				id_len   = marker_len(b);
				id_acc   = {24'd0, b};
				left_cnt = id_len - 4'd1;
			end else begin
				// only the first four ID bytes are kept
				if (id_len - left_cnt < 4)
					id_acc = {id_acc[23:0], b};
				if (left_cnt != 0)
					left_cnt--;
			end
			if (left_cnt == 0) begin
				scan_phase = PH_SIZE;
				size_len   = '0;
			end
			return;
		end
		if (size_len == 0) begin
			size_len = marker_len(b);
			size_acc = {56'd0, b};
			left_cnt = size_len - 4'd1;
		end else begin
			size_acc = {size_acc[55:0], b};
			if (left_cnt != 0)
				left_cnt--;
		end
		if (left_cnt != 0)
			return;

		all_ones   = (64'd1 << (7 * size_len + 1)) - 64'd1;
		undef      = size_acc == all_ones;
		value_bits = size_acc & ((64'd1 << (7 * size_len)) - 64'd1);
		long_id    = id_len > 4;

		rec.element_id          = id_acc;
		rec.id_length           = id_len;
		rec.id_too_long         = long_id;
		rec.size_value          = value_bits[55:0];
		rec.size_length         = size_len;
		rec.size_undefined      = undef;
		rec.size_zero           = value_bits == 0 && !undef;
		rec.size_marker_missing = size_len == 8 && size_acc[63:56] == 8'd0;
		rec.matched             = !long_id && target_id != 0 && id_acc == target_id;
		rec.stop_seen           = !long_id && stop_id != 0 && id_acc == stop_id;
		expected_headers.insert(expected_headers.size(), rec);

		if (rec.stop_seen) begin
			halted = 1'b1;
			await_header();
		end else if (undef || value_bits == 0) begin
			// unknown or zero size: the next header follows straight away
			await_header();
		end else begin
			scan_phase = PH_PAYLOAD;
			skip_cnt   = value_bits[55:0];
			left_cnt   = '0;
		end
	endtask

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t %s: expected %0h, actual %0h", $time, what, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			clear_scan();
			target_id  = '0;
			stop_id    = '0;
			fail_count = 0;
			expected_headers.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TARGET_ID)
					target_id = cfg_data;
				else
					stop_id = cfg_data;
			end
			if (out_valid && out_ready) begin
				if (expected_headers.size() == 0) begin
					$display("%0t record: expected none, actual %0h", $time, out_data);
					fail_count++;
				end else begin
					want = expected_headers.pop_front();
					check_field("element_id", want.element_id, out_data.element_id);
					check_field("id_length", want.id_length, out_data.id_length);
					check_field("id_too_long", want.id_too_long, out_data.id_too_long);
					check_field("size_value", want.size_value, out_data.size_value);
					check_field("size_length", want.size_length, out_data.size_length);
					check_field("size_undefined", want.size_undefined,
						out_data.size_undefined);
					check_field("size_zero", want.size_zero, out_data.size_zero);
					check_field("size_marker_missing", want.size_marker_missing,
						out_data.size_marker_missing);
					check_field("matched", want.matched, out_data.matched);
					check_field("stop_seen", want.stop_seen, out_data.stop_seen);
				end
			end
			if (in_valid && in_ready)
				scan_byte(in_data);
			pending <= expected_headers.size();
		end
	end

endmodule

>>> test/tb.sv
// Testbench top for the EBML element scanner: clock, reset, stimulus and verdict.
module tb;
	import ebsc_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASES      = 6;
	localparam int PHASE_BYTES = 150;

	// Opening stream, start_scan in bit 8: zero size, target with unknown size,
	// zero first ID byte with zero first size byte (largest size), stop element
	// with unknown size, then a byte that must be ignored.
	localparam logic [24*9-1:0] OPENING = {
		9'h181, 9'h080,
		9'h042, 9'h086, 9'h0FF,
		9'h000, 9'h012, 9'h034, 9'h056, 9'h078, 9'h09A, 9'h0BC, 9'h0DE,
		9'h000, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
		9'h1EC, 9'h0FF,
		9'h01F
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_t                  in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_TARGET_ID;
	logic [31:0]          cfg_data  = '0;
	int unsigned          fail_count;
	int unsigned          pending;

	in_t         byte_q[$];
	bit          calm      = 1'b0;
	bit          hold_go   = 1'b0;
	bit          hold_seen = 1'b0;
	int          hold_left = 0;
	int unsigned quiet     = 0;
	int unsigned fed       = 0;
	bit          realign   = 1'b1;
	logic [31:0] tgt_val;
	logic [31:0] stop_val;
	int          tgt_len;
	int          stop_len;

	always #2 clk = ~clk;

	ebml_element_scanner_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ebsc_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Byte sender: a new byte only once the previous transfer has happened.
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= 38)) begin
				in_valid <= 1'b1;
				in_data  <= byte_q.pop_front();
			end else
				in_valid <= 1'b0;
		end
	end

	// Record receiver, with one long hold-off on request.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else
			out_ready <= calm || $urandom_range(0, 99) >= 38;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet <= 0;
		else if (quiet == STALL_LIMIT) begin
			$display("ebml_element_scanner_unit verification failed");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	task automatic feed(input logic [7:0] b, input logic s);
		while (byte_q.size() >= 4)
			@(negedge clk);
		byte_q.insert(byte_q.size(), in_t'({b, s}));
	endtask

	// Stop sending until every byte is taken and every record has come back.
	task automatic drain();
		do
			@(negedge clk);
		while (byte_q.size() != 0 || in_valid || pending != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_regs(input logic [31:0] t, input logic [31:0] s);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_TARGET_ID;
		cfg_data  <= t;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_index <= CFG_STOP_ID;
		cfg_data  <= s;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Well-formed ID of n bytes (1 to 4), marker included.
	function automatic logic [31:0] fresh_id(input int n);
		logic [7:0]  lead;
		logic [31:0] v;
		lead = 8'h80 >> (n - 1);
		v    = {lead | (8'($urandom) & (lead - 8'd1)), 24'($urandom)};
		return v >> (8 * (4 - n));
	endfunction

	task automatic send_element();
		logic [63:0] word;
		logic [63:0] size_val;
		logic [7:0]  lead;
		int          id_n;
		int          sz_n;
		int          pick;
		int          extra;
		bit          s;
		bit          is_stop;
		bit          defined;
		s       = realign || $urandom_range(0, 99) < 5;
		realign = 1'b0;

		pick = $urandom_range(0, 99);
		if (pick < 12 && tgt_len != 0) begin
			id_n = tgt_len;
			word = 64'(tgt_val);
		end else if (pick < 18 && stop_len != 0) begin
			id_n = stop_len;
			word = 64'(stop_val);
		end else if (pick < 24) begin
			// zero first byte: read as eight bytes
			id_n = 8;
			word = {8'h00, 24'($urandom), 32'($urandom)};
		end else if (pick < 34) begin
			id_n = $urandom_range(5, 8);
			word = {32'($urandom), 32'($urandom)};
			lead = 8'h80 >> (id_n - 1);
			word[8*(id_n-1) +: 8] = lead | (word[8*(id_n-1) +: 8] & (lead - 8'd1));
		end else begin
			id_n = $urandom_range(1, 4);
			word = 64'(fresh_id(id_n));
		end
		is_stop = id_n <= 4 && stop_val != 0 && word[31:0] == stop_val;
		for (int i = 0; i < id_n; i++)
			feed(word[8*(id_n-1-i) +: 8], s && i == 0);

		sz_n    = $urandom_range(1, 8);
		defined = 1'b1;
		pick    = $urandom_range(0, 99);
		if (pick < 10) begin
			word    = (64'd1 << (7 * sz_n + 1)) - 64'd1;
			defined = 1'b0;
		end else if (pick < 18)
			word = 64'd1 << (7 * sz_n);
		else if (pick < 23) begin
			// no marker in the first size byte
			sz_n = 8;
			word = {8'h00, 24'($urandom), 32'($urandom)};
		end else if (pick < 28)
			word = (64'd1 << (7 * sz_n))
				| ({32'($urandom), 32'($urandom)} & ((64'd1 << (7 * sz_n)) - 64'd1));
		else
			word = (64'd1 << (7 * sz_n)) | 64'($urandom_range(1, pick < 80 ? 8 : 40));
		size_val = word & ((64'd1 << (7 * sz_n)) - 64'd1);
		for (int i = 0; i < sz_n; i++)
			feed(word[8*(sz_n-1-i) +: 8], 1'b0);
		fed += id_n + sz_n;

		if (is_stop) begin
			// scanner is halted: these bytes are dropped
			repeat ($urandom_range(0, 3)) feed(8'($urandom), 1'b0);
			realign = 1'b1;
		end else if (defined && size_val != 0) begin
			extra = size_val <= 40 ? int'(size_val) : $urandom_range(0, 6);
			repeat (extra) feed(8'($urandom), 1'b0);
			fed += extra;
			realign = size_val > 40;
		end
	endtask

	initial begin
		int n;
		bit held;
		held = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		tgt_val  = 32'h4286;
		tgt_len  = 2;
		stop_val = 32'hEC;
		stop_len = 1;
		write_regs(tgt_val, stop_val);
		for (int i = 23; i >= 0; i--)
			feed(OPENING[9*i +: 8], OPENING[9*i+8]);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1: begin
					tgt_val = 32'hFFFF_FFFF; tgt_len = 0;
					stop_val = 32'h0; stop_len = 0;
				end
				2: begin
					tgt_val = 32'h0; tgt_len = 0;
					stop_val = 32'hFFFF_FFFF; stop_len = 0;
				end
				3: begin
					tgt_val = 32'h1FFF_FFFF; tgt_len = 4;
					stop_val = 32'hFF; stop_len = 1;
				end
				4: begin
					tgt_val = 32'h1000_0000; tgt_len = 4;
					stop_val = 32'h80; stop_len = 1;
				end
				default: begin
					tgt_len  = $urandom_range(1, 4);
					tgt_val  = fresh_id(tgt_len);
					stop_len = $urandom_range(1, 4);
					stop_val = fresh_id(stop_len);
				end
			endcase
			write_regs(tgt_val, stop_val);
			calm    = p == 3;
			realign = 1'b1;
			while (fed < (p + 1) * PHASE_BYTES) begin
				if (p == 2 && !held && fed >= 2 * PHASE_BYTES + 40) begin
					hold_go = !hold_go;
					held    = 1'b1;
				end
				if ($urandom_range(0, 99) < 5) begin
					// broken sequence: stray bytes, stray restarts
					n = $urandom_range(1, 4);
					repeat (n) feed(8'($urandom), 1'($urandom));
					fed += n;
					realign = 1'b1;
				end else
					send_element();
			end
			drain();
		end
		calm = 1'b0;
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("ebml_element_scanner_unit verification clean");
		else
			$display("ebml_element_scanner_unit verification failed");
		$finish;
	end

endmodule

>>> ebml_element_scanner_unit.f
src/ebsc_pkg.sv
src/ebsc_cfg_regs.sv
src/ebsc_parser.sv
src/ebml_element_scanner_unit.sv
test/ebsc_checker.sv
test/tb.sv
